@@ hdl/hbi_pkg.sv @@
// Constants, types and coefficient table shared by the half-band interpolator.
package hbi_pkg;

	localparam int SAMPLE_WIDTH   = 16;
	localparam int COEF_FRAC_BITS = 16;
	localparam int LINE_DEPTH     = 11;
	localparam int HALF_TAPS      = 6;
	localparam int PART_SUMS      = HALF_TAPS / 2;
	localparam int DELAY_TAP      = 4;

	localparam int SUM_WIDTH  = SAMPLE_WIDTH + 1;
	localparam int COEF_WIDTH = 17 + COEF_FRAC_BITS - 16;
	localparam int PROD_WIDTH = SUM_WIDTH + COEF_WIDTH;
	localparam int ACC_WIDTH  = PROD_WIDTH + 3;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [SUM_WIDTH-1:0]    pair_t;
	typedef logic signed [COEF_WIDTH-1:0]   coef_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;

	localparam acc_t SAT_MAX = ACC_WIDTH'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam acc_t SAT_MIN = -SAT_MAX - ACC_WIDTH'(1);

	typedef struct packed {
		logic accept;
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_ctrl_t;

	// Outermost tap pair first; the base values are scaled by 2^16.
	function automatic coef_t coef(input int k);
		int base;
		case (k)
			0:       base = -90;
			1:       base = 502;
			2:       base = -1694;
			3:       base = 4508;
			4:       base = -11204;
			5:       base = 40742;
			default: base = 0;
		endcase
		return COEF_WIDTH'(base * (1 << (COEF_FRAC_BITS - 16)));
	endfunction

endpackage

@@ hdl/hbi_in_if.sv @@
// Input channel carrying one complex sample per request.
interface hbi_in_if;
	logic                 valid;
	logic                 ready;
	hbi_pkg::sample_t     sample_i;
	hbi_pkg::sample_t     sample_q;

	modport source (output valid, output sample_i, output sample_q, input ready);
	modport sink (input valid, input sample_i, input sample_q, output ready);
endinterface

@@ hdl/hbi_out_if.sv @@
// Output channel carrying both interpolator phases per request.
interface hbi_out_if;
	logic                 valid;
	logic                 ready;
	hbi_pkg::sample_t     filtered_i;
	hbi_pkg::sample_t     filtered_q;
	hbi_pkg::sample_t     delayed_i;
	hbi_pkg::sample_t     delayed_q;

	modport source (output valid, output filtered_i, output filtered_q,
		output delayed_i, output delayed_q, input ready);
	modport sink (input valid, input filtered_i, input filtered_q,
		input delayed_i, input delayed_q, output ready);
endinterface

@@ hdl/halfband_interpolator_complex.sv @@
// Top level of the complex 2x half-band interpolator.
// Each request on the sample channel carries one complex sample and yields one
// request on the result channel with both output phases: the filtered phase of a
// 12-tap symmetric half-band FIR, floor shifted and saturated to the sample width,
// and the input delayed by five samples. The block takes one sample in every clock
// cycle while the pipeline is not stalled; a sample passes through the pre-add,
// multiply, partial-sum and final-sum register stages in that order on its way to
// the output. Every stage holds when the stage after it is full and stalled, so
// the block keeps accepting samples into empty stages while a result waits. After
// reset the delay lines hold zeros.
module halfband_interpolator_complex (
	input  logic       clk,
	input  logic       arst_n,
	hbi_in_if.sink     samples,
	hbi_out_if.source  results
);

	hbi_pkg::pipe_ctrl_t ctrl;
	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s3;
	logic                valid_s4;

	hbi_pkg::pair_t      pair_i_s1 [hbi_pkg::HALF_TAPS];
	hbi_pkg::pair_t      pair_q_s1 [hbi_pkg::HALF_TAPS];
	hbi_pkg::sample_t    delayed_i_s1;
	hbi_pkg::sample_t    delayed_q_s1;

	always_comb begin
		ctrl.en_s4  = !valid_s4 || results.ready;
		ctrl.en_s3  = !valid_s3 || ctrl.en_s4;
		ctrl.en_s2  = !valid_s2 || ctrl.en_s3;
		ctrl.en_s1  = !valid_s1 || ctrl.en_s2;
		ctrl.accept = samples.valid && ctrl.en_s1;
	end

	assign samples.ready = ctrl.en_s1;
	assign results.valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ctrl.en_s1) begin
				valid_s1 <= samples.valid;
			end
			if (ctrl.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ctrl.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ctrl.en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	hbi_preadd u_preadd_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample     (samples.sample_i),
		.pair_s1    (pair_i_s1),
		.delayed_s1 (delayed_i_s1)
	);

	hbi_preadd u_preadd_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.sample     (samples.sample_q),
		.pair_s1    (pair_q_s1),
		.delayed_s1 (delayed_q_s1)
	);

	hbi_mac u_mac_i (
		.clk         (clk),
		.ctrl        (ctrl),
		.pair_s1     (pair_i_s1),
		.delayed_s1  (delayed_i_s1),
		.filtered_s4 (results.filtered_i),
		.delayed_s4  (results.delayed_i)
	);

	hbi_mac u_mac_q (
		.clk         (clk),
		.ctrl        (ctrl),
		.pair_s1     (pair_q_s1),
		.delayed_s1  (delayed_q_s1),
		.filtered_s4 (results.filtered_q),
		.delayed_s4  (results.delayed_q)
	);

endmodule

@@ hdl/hbi_preadd.sv @@
// Sample delay line and symmetric tap pre-adders for one channel.
module hbi_preadd (
	input  logic                clk,
	input  logic                arst_n,
	input  hbi_pkg::pipe_ctrl_t ctrl,
	input  hbi_pkg::sample_t    sample,
	output hbi_pkg::pair_t      pair_s1 [hbi_pkg::HALF_TAPS],
	output hbi_pkg::sample_t    delayed_s1
);

	hbi_pkg::sample_t line_q [hbi_pkg::LINE_DEPTH];
	hbi_pkg::sample_t taps [hbi_pkg::LINE_DEPTH + 1];

	always_comb begin
		taps[0] = sample;
		for (int k = 0; k < hbi_pkg::LINE_DEPTH; k++) begin
			taps[k + 1] = line_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < hbi_pkg::LINE_DEPTH; k++) begin
				line_q[k] <= '0;
			end
		end else if (ctrl.accept) begin
			line_q[0] <= sample;
			for (int k = 1; k < hbi_pkg::LINE_DEPTH; k++) begin
				line_q[k] <= line_q[k - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s1) begin
			for (int k = 0; k < hbi_pkg::HALF_TAPS; k++) begin
				pair_s1[k] <= hbi_pkg::SUM_WIDTH'(taps[k])
					+ hbi_pkg::SUM_WIDTH'(taps[hbi_pkg::LINE_DEPTH - k]);
			end
			delayed_s1 <= line_q[hbi_pkg::DELAY_TAP];
		end
	end

endmodule

@@ hdl/hbi_mac.sv @@
// Coefficient multipliers, adder tree, floor shift and saturation for one channel.
module hbi_mac (
	input  logic                clk,
	input  hbi_pkg::pipe_ctrl_t ctrl,
	input  hbi_pkg::pair_t      pair_s1 [hbi_pkg::HALF_TAPS],
	input  hbi_pkg::sample_t    delayed_s1,
	output hbi_pkg::sample_t    filtered_s4,
	output hbi_pkg::sample_t    delayed_s4
);

	hbi_pkg::prod_t   prod_s2 [hbi_pkg::HALF_TAPS];
	hbi_pkg::acc_t    part_s3 [hbi_pkg::PART_SUMS];
	hbi_pkg::sample_t delayed_s2;
	hbi_pkg::sample_t delayed_s3;
	hbi_pkg::acc_t    total;
	hbi_pkg::acc_t    shifted;
	hbi_pkg::sample_t clamped;

	always_ff @(posedge clk) begin
		if (ctrl.en_s2) begin
			for (int k = 0; k < hbi_pkg::HALF_TAPS; k++) begin
				prod_s2[k] <= hbi_pkg::PROD_WIDTH'(pair_s1[k])
					* hbi_pkg::PROD_WIDTH'(hbi_pkg::coef(k));
			end
			delayed_s2 <= delayed_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s3) begin
			for (int j = 0; j < hbi_pkg::PART_SUMS; j++) begin
				part_s3[j] <= hbi_pkg::ACC_WIDTH'(prod_s2[2 * j])
					+ hbi_pkg::ACC_WIDTH'(prod_s2[2 * j + 1]);
			end
			delayed_s3 <= delayed_s2;
		end
	end

	always_comb begin
		total = '0;
		for (int j = 0; j < hbi_pkg::PART_SUMS; j++) begin
			total = total + part_s3[j];
		end
		shifted = total >>> hbi_pkg::COEF_FRAC_BITS;
		if (shifted > hbi_pkg::SAT_MAX) begin
			clamped = hbi_pkg::SAMPLE_WIDTH'(hbi_pkg::SAT_MAX);
		end else if (shifted < hbi_pkg::SAT_MIN) begin
			clamped = hbi_pkg::SAMPLE_WIDTH'(hbi_pkg::SAT_MIN);
		end else begin
			clamped = hbi_pkg::SAMPLE_WIDTH'(shifted);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en_s4) begin
			filtered_s4 <= clamped;
			delayed_s4  <= delayed_s3;
		end
	end

endmodule
